FILE: sv/bzr_pkg.sv
// Shared constants and types for the cubic Bezier point evaluator.
// Fixed-point widths, register indexes and the result select code.
// No dependencies.
package bzr_pkg;

  // Fixed-point format
  localparam int FracBits = 16;
  localparam int CoordW   = 32;
  localparam int ParamW   = 18;
  // t carried wide enough to hold "one" as a positive signed value
  localparam int TMulW    = (FracBits + 2 > ParamW) ? FracBits + 2 : ParamW;
  localparam int DiffW    = CoordW + 1;
  localparam int ProdW    = DiffW + TMulW;

  // Configuration registers
  localparam int NumRegs  = 8;
  localparam int CfgIdxW  = $clog2(NumRegs);
  localparam logic [CfgIdxW-1:0] RegStartX  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegStartY  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegGuide1X = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegGuide1Y = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegGuide2X = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegGuide2Y = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] RegEndX    = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] RegEndY    = CfgIdxW'(7);

  // Pipeline depth of one interpolation level
  localparam int LerpStages = 3;

  // Which value the output stage returns
  typedef enum logic [1:0] {
    SelCurve,
    SelStart,
    SelEnd
  } sel_e;

endpackage

FILE: sv/bzr_lerp.sv
// One linear interpolation a + floor((b - a) * t / 2^FracBits), three stages:
// difference, multiply, shift and add. Depends on bzr_pkg.
module bzr_lerp (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [bzr_pkg::CoordW-1:0]   a_i,
  input  logic signed [bzr_pkg::CoordW-1:0]   b_i,
  input  logic signed [bzr_pkg::TMulW-1:0]    t_i,
  output logic signed [bzr_pkg::CoordW-1:0]   y_o
);

  logic signed [bzr_pkg::DiffW-1:0]  diff_d, diff_q;
  logic signed [bzr_pkg::CoordW-1:0] a1_q, a2_q;
  logic signed [bzr_pkg::TMulW-1:0]  t1_q;
  logic signed [bzr_pkg::ProdW-1:0]  prod_d, prod_q;
  logic signed [bzr_pkg::CoordW-1:0] y_d, y_q;

  // stage 1: difference
  assign diff_d = bzr_pkg::DiffW'(b_i) - bzr_pkg::DiffW'(a_i);
  // stage 2: signed product
  assign prod_d = bzr_pkg::ProdW'(diff_q) * bzr_pkg::ProdW'(t1_q);
  // stage 3: arithmetic shift is a plain part-select; result fits 32 bits
  assign y_d = a2_q + $signed(prod_q[bzr_pkg::FracBits + bzr_pkg::CoordW - 1:
                                     bzr_pkg::FracBits]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
      a1_q   <= a_i;
      t1_q   <= t_i;
      prod_q <= prod_d;
      a2_q   <= a1_q;
      y_q    <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

FILE: sv/cubic_bezier_point_eval_top.sv
// Cubic Bezier point evaluator, top level: config registers, three
// interpolation levels of bzr_lerp and the output select. Depends on bzr_pkg.
// Path from accepted t to result: 3 levels x 3 stages, then the output register.
// Throughput: one transaction per cycle; a stalled result freezes the pipeline.
// Reset clears all valid bits and sets every control point to zero.
module cubic_bezier_point_eval_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [bzr_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [bzr_pkg::CoordW-1:0]            cfg_wdata_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [bzr_pkg::ParamW-1:0]     param_t_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bzr_pkg::CoordW-1:0]     point_x_o,
  output logic signed [bzr_pkg::CoordW-1:0]     point_y_o
);

  localparam int PipeD = 3 * bzr_pkg::LerpStages;
  localparam int TDepth = 2 * bzr_pkg::LerpStages;
  localparam logic signed [bzr_pkg::TMulW-1:0] OneT =
    bzr_pkg::TMulW'({1'b1, {bzr_pkg::FracBits{1'b0}}});

  logic signed [bzr_pkg::CoordW-1:0] cfg_q [bzr_pkg::NumRegs];

  logic                              en;
  logic signed [bzr_pkg::TMulW-1:0]  t_ext;
  bzr_pkg::sel_e                     sel_d;
  logic [PipeD-1:0]                  vld_q;
  bzr_pkg::sel_e                     sel_q [PipeD];
  logic signed [bzr_pkg::TMulW-1:0]  t_q [TDepth];

  logic signed [bzr_pkg::CoordW-1:0] l1_y [2][3];
  logic signed [bzr_pkg::CoordW-1:0] l2_y [2][2];
  logic signed [bzr_pkg::CoordW-1:0] l3_y [2];

  logic                              out_vld_q;
  logic signed [bzr_pkg::CoordW-1:0] px_d, py_d, px_q, py_q;

  // whole pipeline advances unless a finished result is held back
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bzr_pkg::NumRegs; i++) cfg_q[i] <= '0;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // classify t at entry
  assign t_ext = bzr_pkg::TMulW'(param_t_i);
  always_comb begin
    priority if (param_t_i[bzr_pkg::ParamW-1]) begin
      sel_d = bzr_pkg::SelStart;
    end else if (t_ext >= OneT) begin
      sel_d = bzr_pkg::SelEnd;
    end else begin
      sel_d = bzr_pkg::SelCurve;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PipeD-2:0], in_valid_i};
      out_vld_q <= vld_q[PipeD-1];
    end
  end

  // select code and t travel with the item
  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_q[0] <= sel_d;
      t_q[0]   <= t_ext;
      for (int i = 1; i < PipeD; i++) sel_q[i] <= sel_q[i-1];
      for (int i = 1; i < TDepth; i++) t_q[i] <= t_q[i-1];
    end
  end

  // interpolation levels, per axis
  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    for (genvar k = 0; k < 3; k++) begin : g_l1
      bzr_lerp u_l1 (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (cfg_q[2*k + ax]),
        .b_i   (cfg_q[2*k + 2 + ax]),
        .t_i   (t_ext),
        .y_o   (l1_y[ax][k])
      );
    end
    for (genvar k = 0; k < 2; k++) begin : g_l2
      bzr_lerp u_l2 (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (l1_y[ax][k]),
        .b_i   (l1_y[ax][k+1]),
        .t_i   (t_q[bzr_pkg::LerpStages-1]),
        .y_o   (l2_y[ax][k])
      );
    end
    bzr_lerp u_l3 (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (l2_y[ax][0]),
      .b_i   (l2_y[ax][1]),
      .t_i   (t_q[TDepth-1]),
      .y_o   (l3_y[ax])
    );
  end

  // output select: curve point, or an end point for out-of-range t
  always_comb begin
    unique case (sel_q[PipeD-1])
      bzr_pkg::SelStart: begin
        px_d = cfg_q[bzr_pkg::RegStartX];
        py_d = cfg_q[bzr_pkg::RegStartY];
      end
      bzr_pkg::SelEnd: begin
        px_d = cfg_q[bzr_pkg::RegEndX];
        py_d = cfg_q[bzr_pkg::RegEndY];
      end
      default: begin
        px_d = l3_y[0];
        py_d = l3_y[1];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;

  // checks
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_t_range_l2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[bzr_pkg::LerpStages-1] && sel_q[bzr_pkg::LerpStages-1] == bzr_pkg::SelCurve)
    |-> (t_q[bzr_pkg::LerpStages-1] >= 0 && t_q[bzr_pkg::LerpStages-1] < OneT))
    else $error("curve item with t outside [0, one) at level 2");

  a_t_range_l3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[TDepth-1] && sel_q[TDepth-1] == bzr_pkg::SelCurve)
    |-> (t_q[TDepth-1] >= 0 && t_q[TDepth-1] < OneT))
    else $error("curve item with t outside [0, one) at level 3");

  // while reset is held, the pipeline is empty and no result is valid
  a_reset_empty: assert property (@(posedge clk_i)
    (!rst_ni ##1 !rst_ni) |-> (!out_valid_o && vld_q == '0))
    else $error("pipeline not empty during reset");

endmodule
